>>> rtl/fit_policy_block_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fit policy block allocator
// Clocked property checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FPBA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPBA_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);
`else
`define FPBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPBA_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg)
`endif
`endif

>>> rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared constants, codes and types of the fit policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

	localparam int DEF_MAX_BLOCKS = 32;
	localparam int DEF_SIZE_BITS  = 16;

	localparam int AMOUNT_W   = 16;
	localparam int INDEX_W    = 5;
	localparam int CHOSEN_W   = 5;
	localparam int STATUS_W   = 2;
	localparam int TOTAL_W    = 21;
	localparam int FIT_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [TOTAL_W-1:0]    TOTAL_MAX       = {TOTAL_W{1'b1}};
	localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 6'd32;
	localparam logic [FIT_W-1:0]      FIT_MODE_RST    = 2'd0;

	localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_LOADED = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_GRANT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_WAIT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_FIX,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic start;
		logic load_wr;
		logic rd_en;
		logic smp_vld;
		logic fix;
		logic done_ld;
	} ctl_t;

endpackage

`default_nettype wire

>>> rtl/fpba_table.sv
// ----------------------------------------------------------------------------
// fpba_table
// Block size memory with one write and one registered read port, plus
// per-entry valid and touched flags.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_table #(
	parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS,
	parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(MAX_BLOCKS)-1:0] wr_addr,
	input  wire logic [SIZE_BITS-1:0]          wr_data,
	input  wire logic                          wr_touched,
	output logic      [SIZE_BITS-1:0]          rd_data,
	output logic                               rd_touched
);

	logic [SIZE_BITS-1:0]  mem [MAX_BLOCKS];
	logic [SIZE_BITS-1:0]  mem_rd_s1;
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [MAX_BLOCKS-1:0] touched_q;
	logic                  valid_rd_s1;
	logic                  touched_rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			touched_q     <= '0;
			valid_rd_s1   <= 1'b0;
			touched_rd_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr]   <= 1'b1;
				touched_q[wr_addr] <= wr_touched;
			end
			if (rd_en) begin
				valid_rd_s1   <= valid_q[rd_addr];
				touched_rd_s1 <= touched_q[rd_addr];
			end
		end
	end

	assign rd_data    = valid_rd_s1 ? mem_rd_s1 : '0;
	assign rd_touched = valid_rd_s1 & touched_rd_s1;

endmodule

`default_nettype wire

>>> rtl/fpba_fit_unit.sv
// ----------------------------------------------------------------------------
// fpba_fit_unit
// Shared compare and accumulate unit: picks the block by fit policy from the
// streamed table entries and keeps the fragmentation sums.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_fit_unit #(
	parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS,
	parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire fpba_pkg::ctl_t                        ctl,
	input  wire logic [fpba_pkg::FIT_W-1:0]            fit_mode,
	input  wire logic                                  is_alloc,
	input  wire logic [fpba_pkg::AMOUNT_W-1:0]         amount,
	input  wire logic [SIZE_BITS-1:0]                  smp_data,
	input  wire logic                                  smp_touched,
	input  wire logic [$clog2(MAX_BLOCKS)-1:0]         smp_idx,
	output logic                                       found,
	output logic      [$clog2(MAX_BLOCKS)-1:0]         pick,
	output logic      [SIZE_BITS-1:0]                  new_size,
	output logic      [fpba_pkg::TOTAL_W-1:0]          internal_total,
	output logic      [fpba_pkg::TOTAL_W-1:0]          external_total
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int ACC_W = SIZE_BITS + CNT_W;
	localparam int CW    = (SIZE_BITS > fpba_pkg::AMOUNT_W) ? SIZE_BITS : fpba_pkg::AMOUNT_W;
	localparam int SW    = (ACC_W > fpba_pkg::TOTAL_W) ? ACC_W : fpba_pkg::TOTAL_W;

	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic                 pick_touched_q;
	logic [ACC_W-1:0]     in_sum_q;
	logic [ACC_W-1:0]     ex_sum_q;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic [SW-1:0]        in_ext;
	logic [SW-1:0]        ex_ext;

	assign fits = CW'(amount) <= CW'(smp_data);

	always_comb begin
		case (fit_mode)
			fpba_pkg::FIT_BEST:  better = smp_data < best_q;
			fpba_pkg::FIT_WORST: better = smp_data > best_q;
			default:             better = 1'b0;
		endcase
	end

	assign take     = is_alloc & fits & (~found_q | better);
	assign new_size = best_q - SIZE_BITS'(amount);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (ctl.smp_vld && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			in_sum_q <= '0;
			ex_sum_q <= '0;
		end else if (ctl.smp_vld) begin
			if (smp_touched) begin
				in_sum_q <= in_sum_q + ACC_W'(smp_data);
			end else begin
				ex_sum_q <= ex_sum_q + ACC_W'(smp_data);
			end
		end else if (ctl.fix && found_q) begin
			if (pick_touched_q) begin
				in_sum_q <= in_sum_q - ACC_W'(amount);
			end else begin
				ex_sum_q <= ex_sum_q - ACC_W'(best_q);
				in_sum_q <= in_sum_q + ACC_W'(new_size);
			end
		end
		if (ctl.smp_vld && take) begin
			pick_q         <= smp_idx;
			best_q         <= smp_data;
			pick_touched_q <= smp_touched;
		end
	end

	assign in_ext = SW'(in_sum_q);
	assign ex_ext = SW'(ex_sum_q);

	assign internal_total = (in_ext > SW'(fpba_pkg::TOTAL_MAX)) ? fpba_pkg::TOTAL_MAX
		: in_ext[fpba_pkg::TOTAL_W-1:0];
	assign external_total = (ex_ext > SW'(fpba_pkg::TOTAL_MAX)) ? fpba_pkg::TOTAL_MAX
		: ex_ext[fpba_pkg::TOTAL_W-1:0];

	assign found = found_q;
	assign pick  = pick_q;

endmodule

`default_nettype wire

>>> rtl/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: load write, table scan with read address counter, fix-up and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ctrl #(
	parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire logic                              opcode,
	input  wire logic                              opcode_q,
	input  wire logic [$clog2(MAX_BLOCKS+1)-1:0]   n_blocks,
	input  wire logic                              out_free,
	output fpba_pkg::ctl_t                         ctl,
	output logic      [$clog2(MAX_BLOCKS)-1:0]     rd_addr,
	output logic      [$clog2(MAX_BLOCKS)-1:0]     smp_idx
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	fpba_pkg::state_t state_q;
	fpba_pkg::state_t state_nxt;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             smp_vld_s1;
	logic [IDX_W-1:0] smp_idx_s1;
	logic             scan_more;

	assign scan_more = rd_cnt_q < n_blocks;
	assign rd_addr   = rd_cnt_q[IDX_W-1:0];

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fpba_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = (opcode == fpba_pkg::OP_LOAD) ? fpba_pkg::S_LOAD
						: fpba_pkg::S_SCAN;
				end
			end
			fpba_pkg::S_LOAD: state_nxt = fpba_pkg::S_SCAN;
			fpba_pkg::S_SCAN: begin
				if (!scan_more && !smp_vld_s1) begin
					state_nxt = (opcode_q == fpba_pkg::OP_ALLOC) ? fpba_pkg::S_FIX
						: fpba_pkg::S_DONE;
				end
			end
			fpba_pkg::S_FIX:  state_nxt = fpba_pkg::S_DONE;
			fpba_pkg::S_DONE: begin
				if (out_free) begin
					state_nxt = fpba_pkg::S_IDLE;
				end
			end
			default: state_nxt = fpba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl         = '0;
		ctl.smp_vld = smp_vld_s1;
		unique case (state_q)
			fpba_pkg::S_IDLE: ctl.start   = in_valid;
			fpba_pkg::S_LOAD: ctl.load_wr = 1'b1;
			fpba_pkg::S_SCAN: ctl.rd_en   = scan_more;
			fpba_pkg::S_FIX:  ctl.fix     = 1'b1;
			fpba_pkg::S_DONE: ctl.done_ld = out_free;
			default: ;
		endcase
		ctl.busy = state_q != fpba_pkg::S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fpba_pkg::S_IDLE;
			rd_cnt_q   <= '0;
			smp_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			smp_vld_s1 <= ctl.rd_en;
			if (ctl.start) begin
				rd_cnt_q <= '0;
			end else if (ctl.rd_en) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			smp_idx_s1 <= rd_addr;
		end
	end

	assign smp_idx = smp_idx_s1;

endmodule

`default_nettype wire

>>> rtl/fit_policy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Block table allocator with first, best and worst fit and running
// fragmentation totals.
// ----------------------------------------------------------------------------
// One item at a time: a new item is accepted only after the previous result
// has been handed off; a result waits in the done state while a previous
// result is still stalled in the output register. Each item's time is set by
// the table scan over n blocks, n being the number of blocks in use (min of
// block_count and MAX_BLOCKS): every item streams the n block entries
// through the single read port of the block memory into one compare and
// accumulate unit, one entry per cycle, which both picks the block and
// rebuilds the totals.
// Configuration writes are always ready and take effect at once.
`default_nettype none
`include "fit_policy_block_allocator_unit_macros.svh"

module fit_policy_block_allocator_unit #(
	parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS,
	parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              opcode,
	input  wire logic [fpba_pkg::INDEX_W-1:0]      block_index,
	input  wire logic [fpba_pkg::AMOUNT_W-1:0]     amount,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [fpba_pkg::STATUS_W-1:0]     status,
	output logic      [fpba_pkg::CHOSEN_W-1:0]     chosen_block,
	output logic      [fpba_pkg::AMOUNT_W-1:0]     remaining_after,
	output logic      [fpba_pkg::TOTAL_W-1:0]      internal_fragment,
	output logic      [fpba_pkg::TOTAL_W-1:0]      external_fragment,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int BCW   = (CNT_W > fpba_pkg::CFG_DATA_W) ? CNT_W : fpba_pkg::CFG_DATA_W;
	localparam int AIW   = (CNT_W > fpba_pkg::INDEX_W) ? CNT_W : fpba_pkg::INDEX_W;

	fpba_pkg::ctl_t ctl;

	logic [fpba_pkg::FIT_W-1:0]      fit_mode_q;
	logic [fpba_pkg::CFG_DATA_W-1:0] block_count_q;
	logic                            opcode_q;
	logic [fpba_pkg::INDEX_W-1:0]    index_q;
	logic [fpba_pkg::AMOUNT_W-1:0]   amount_q;

	logic                            out_valid_q;
	logic [fpba_pkg::STATUS_W-1:0]   status_q;
	logic [fpba_pkg::CHOSEN_W-1:0]   chosen_q;
	logic [fpba_pkg::AMOUNT_W-1:0]   left_q;
	logic [fpba_pkg::TOTAL_W-1:0]    in_frag_q;
	logic [fpba_pkg::TOTAL_W-1:0]    ex_frag_q;

	logic [BCW-1:0]                  bc_ext;
	logic [CNT_W-1:0]                n_blocks;
	logic [AIW-1:0]                  idx_ext;
	logic                            load_in_range;
	logic                            out_free;
	logic                            granted;

	logic [IDX_W-1:0]                rd_addr;
	logic [IDX_W-1:0]                smp_idx;
	logic [SIZE_BITS-1:0]            smp_data;
	logic                            smp_touched;
	logic                            tbl_we;
	logic [IDX_W-1:0]                tbl_waddr;
	logic [SIZE_BITS-1:0]            tbl_wdata;

	logic                            found;
	logic [IDX_W-1:0]                pick;
	logic [SIZE_BITS-1:0]            new_size;
	logic [fpba_pkg::TOTAL_W-1:0]    internal_total;
	logic [fpba_pkg::TOTAL_W-1:0]    external_total;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= fpba_pkg::FIT_MODE_RST;
			block_count_q <= fpba_pkg::BLOCK_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fpba_pkg::REG_FIT_MODE:    fit_mode_q    <= cfg_data[fpba_pkg::FIT_W-1:0];
				fpba_pkg::REG_BLOCK_COUNT: block_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bc_ext   = BCW'(block_count_q);
	assign n_blocks = (bc_ext > BCW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bc_ext);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			opcode_q <= opcode;
			index_q  <= block_index;
			amount_q <= amount;
		end
	end

	assign idx_ext       = AIW'(index_q);
	assign load_in_range = idx_ext < AIW'(MAX_BLOCKS);

	assign tbl_we    = ctl.load_wr ? load_in_range : (ctl.fix & found);
	assign tbl_waddr = ctl.load_wr ? idx_ext[IDX_W-1:0] : pick;
	assign tbl_wdata = ctl.load_wr ? SIZE_BITS'(amount_q) : new_size;

	assign out_free = ~out_valid_q | ~out_stall;
	assign in_stall = ctl.busy;

	fpba_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.opcode_q (opcode_q),
		.n_blocks (n_blocks),
		.out_free (out_free),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.smp_idx  (smp_idx)
	);

	fpba_table #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (ctl.rd_en),
		.rd_addr    (rd_addr),
		.wr_en      (tbl_we),
		.wr_addr    (tbl_waddr),
		.wr_data    (tbl_wdata),
		.wr_touched (~ctl.load_wr),
		.rd_data    (smp_data),
		.rd_touched (smp_touched)
	);

	fpba_fit_unit #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_fit (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.fit_mode       (fit_mode_q),
		.is_alloc       (opcode_q == fpba_pkg::OP_ALLOC),
		.amount         (amount_q),
		.smp_data       (smp_data),
		.smp_touched    (smp_touched),
		.smp_idx        (smp_idx),
		.found          (found),
		.pick           (pick),
		.new_size       (new_size),
		.internal_total (internal_total),
		.external_total (external_total)
	);

	assign granted = (opcode_q == fpba_pkg::OP_ALLOC) & found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.done_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done_ld) begin
			if (opcode_q == fpba_pkg::OP_LOAD) begin
				status_q <= fpba_pkg::STAT_LOADED;
			end else if (found) begin
				status_q <= fpba_pkg::STAT_GRANT;
			end else begin
				status_q <= fpba_pkg::STAT_WAIT;
			end
			chosen_q  <= granted ? fpba_pkg::CHOSEN_W'(pick) : '0;
			left_q    <= granted ? fpba_pkg::AMOUNT_W'(new_size) : '0;
			in_frag_q <= internal_total;
			ex_frag_q <= external_total;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign chosen_block      = chosen_q;
	assign remaining_after   = left_q;
	assign internal_fragment = in_frag_q;
	assign external_fragment = ex_frag_q;

	`FPBA_ASSERT(a_scan_no_write, clk, arst_n, ctl.rd_en |-> !tbl_we, "table written during scan")
	`FPBA_ASSERT_NEXT(a_start_busy, clk, arst_n, ctl.start, in_stall, "not busy after accept")
	`FPBA_ASSERT_NEXT(a_result_shown, clk, arst_n, ctl.done_ld, out_valid, "result not presented")
	`FPBA_ASSERT(a_nogrant_zero, clk, arst_n, (out_valid && status != fpba_pkg::STAT_GRANT) |-> (chosen_block == '0 && remaining_after == '0), "non-grant item with block data")

endmodule

`default_nettype wire
